// ----- src/rcad_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcad_pkg
// Types and constants for the RC channel averaging and deadband block.
// ----------------------------------------------------------------------------
package rcad_pkg;

  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned CHANNEL_W  = 4;
  localparam int unsigned HIST_DEPTH = 3;
  localparam int unsigned SLOT_W     = 2;
  localparam int unsigned SUM_W      = 14;
  localparam int unsigned DEADBAND   = 3;
  localparam int unsigned OFFSET     = 2;
  localparam int unsigned ROUNDING   = 2;

  typedef logic [SAMPLE_W-1:0]  sample_t;
  typedef logic [CHANNEL_W-1:0] channel_t;
  typedef logic [SLOT_W-1:0]    slot_t;
  typedef logic [SUM_W-1:0]     sum_t;

  // receiver_mode codes; the unused code 3 runs as pulse mode
  typedef enum logic [1:0] {
    MODE_PULSE       = 2'd0,
    MODE_SERIAL_FLAG = 2'd1,
    MODE_SERIAL      = 2'd2
  } rx_mode_t;

  typedef enum logic {
    REG_MODE      = 1'b0,
    REG_THRESHOLD = 1'b1
  } reg_index_t;

  localparam slot_t LAST_SLOT = slot_t'(HIST_DEPTH - 1);

endpackage : rcad_pkg
`default_nettype wire

// ----- src/rc_channel_average_deadband.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc_channel_average_deadband
// Per-channel four-sample rounded average with deadband for pulse receivers,
// direct pass-through of accepted samples for serial-bus receivers.
// ----------------------------------------------------------------------------
// Channel   Signals                                          Dir
// input     in_valid, in_stall, channel, pulse_value,        in (in_stall out)
//           frame_start, armed, link_failsafe
// output    out_valid, out_stall, out_channel,               out (out_stall in)
//           filtered_value, accepted
// config    cfg_write, cfg_index, cfg_data                   in
//
// One item per cycle while the output is not stalled.
// Stage 1 registers the item, slot and acceptance; stage 2 reads the channel's
// history row, sums and stores the sample; the output stage reads and updates
// the held value. Each channel store is read and written in one stage, so
// back-to-back items on the same channel need no forwarding.
// Reset clears all stores and the history slot.
// Each stage holds while the next is full and stalled; bubbles collapse.
// ----------------------------------------------------------------------------
module rc_channel_average_deadband
  import rcad_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = 12
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     cfg_write,
  input  wire logic     cfg_index,
  input  wire sample_t  cfg_data,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire channel_t channel,
  input  wire sample_t  pulse_value,
  input  wire logic     frame_start,
  input  wire logic     armed,
  input  wire logic     link_failsafe,
  output logic          out_valid,
  input  wire logic     out_stall,
  output channel_t      out_channel,
  output sample_t       filtered_value,
  output logic          accepted
);

  localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [CHANNEL_W:0] CH_LIMIT = (CHANNEL_W + 1)'(NUM_CHANNELS);

  // configuration
  logic [1:0] receiver_mode;
  sample_t    failsafe_threshold;

  // channel stores
  sample_t [HIST_DEPTH-1:0] sample_history [NUM_CHANNELS];
  sample_t                  held_value     [NUM_CHANNELS];
  slot_t                    history_slot;
  slot_t                    history_slot_next;

  // stage 1
  logic     s1_valid;
  channel_t s1_channel;
  sample_t  s1_sample;
  slot_t    s1_slot;
  logic     s1_acc;

  // stage 2
  logic     s2_valid;
  channel_t s2_channel;
  sample_t  s2_sample;
  sample_t  s2_avg;
  logic     s2_acc;
  logic     s2_in_range;

  logic     pulse_mode;
  logic     in_fire, s1_fire, s2_fire;
  logic     out_ready, s2_ready, s1_ready;
  logic     acc_in;
  logic     s1_in_range;
  logic     hist_write;
  logic [IDX_W-1:0] s1_idx, s2_idx;
  sample_t [HIST_DEPTH-1:0] s1_row;
  sum_t     sum;
  sample_t  avg;
  sample_t  held_old, held_mid, held_new;

  assign pulse_mode = (receiver_mode != MODE_SERIAL_FLAG) && (receiver_mode != MODE_SERIAL);

  // handshake
  assign out_ready = !out_valid || !out_stall;
  assign s2_ready  = !s2_valid || out_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign in_stall  = !s1_ready;
  assign in_fire   = in_valid && s1_ready;
  assign s1_fire   = s1_valid && s2_ready;
  assign s2_fire   = s2_valid && out_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      receiver_mode      <= MODE_PULSE;
      failsafe_threshold <= '0;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_MODE:      receiver_mode      <= cfg_data[1:0];
        REG_THRESHOLD: failsafe_threshold <= cfg_data;
        default:       ;
      endcase
    end
  end

  // input: slot advance and acceptance test
  always_comb begin
    history_slot_next = history_slot;
    if (frame_start) begin
      history_slot_next = (history_slot == LAST_SLOT) ? '0 : history_slot + slot_t'(1);
    end
    if (receiver_mode == MODE_SERIAL_FLAG) begin
      acc_in = link_failsafe || !armed;
    end else begin
      acc_in = (pulse_value > failsafe_threshold) || !armed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      history_slot <= '0;
      s1_valid     <= 1'b0;
    end else begin
      if (in_fire) begin
        history_slot <= history_slot_next;
        s1_valid     <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_channel <= channel;
      s1_sample  <= pulse_value;
      s1_slot    <= history_slot_next;
      s1_acc     <= acc_in;
    end
  end

  // stage 2: history read, rounded average, history store
  assign s1_in_range = {1'b0, s1_channel} < CH_LIMIT;
  assign s1_idx      = s1_channel[IDX_W-1:0];
  assign s1_row      = sample_history[s1_idx];
  assign hist_write  = s1_fire && s1_acc && s1_in_range && pulse_mode;

  always_comb begin
    sum = sum_t'(s1_sample) + sum_t'(ROUNDING);
    for (int k = 0; k < HIST_DEPTH; k++) begin
      sum = sum + sum_t'(s1_row[k]);
    end
    avg = sample_t'(sum >> 2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        sample_history[c] <= '0;
      end
    end else if (hist_write) begin
      sample_history[s1_idx][s1_slot] <= s1_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_fire) begin
      s2_valid <= 1'b1;
    end else if (s2_fire) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      s2_channel  <= s1_channel;
      s2_sample   <= s1_sample;
      s2_avg      <= avg;
      s2_acc      <= s1_acc && s1_in_range;
      s2_in_range <= s1_in_range;
    end
  end

  // stage 3: held value read, deadband, held store
  assign s2_idx   = s2_channel[IDX_W-1:0];
  assign held_old = held_value[s2_idx];

  always_comb begin
    held_mid = held_old;
    // pull down toward the average when it drops below the band
    if (({1'b0, s2_avg} + (SAMPLE_W + 1)'(DEADBAND)) < {1'b0, held_old}) begin
      held_mid = s2_avg + sample_t'(OFFSET);
    end
    held_new = held_mid;
    if ({1'b0, s2_avg} > ({1'b0, held_mid} + (SAMPLE_W + 1)'(DEADBAND))) begin
      held_new = s2_avg - sample_t'(OFFSET);
    end
    if (!s2_acc) begin
      held_new = held_old;
    end else if (!pulse_mode) begin
      held_new = s2_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        held_value[c] <= '0;
      end
    end else if (s2_fire && s2_acc) begin
      held_value[s2_idx] <= held_new;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      out_channel    <= s2_channel;
      filtered_value <= s2_in_range ? held_new : '0;
      accepted       <= s2_acc;
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    (history_slot != 2'd3))
    else $error("history slot left its range");

  a_out_of_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ({1'b0, out_channel} >= CH_LIMIT)) |-> (!accepted && (filtered_value == '0)))
    else $error("out-of-range channel reported a value");

  a_deadband: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_acc && pulse_mode) |->
      (({1'b0, held_new} + (SAMPLE_W + 1)'(DEADBAND)) >= {1'b0, s2_avg}) &&
      (({1'b0, s2_avg} + (SAMPLE_W + 1)'(DEADBAND)) >= {1'b0, held_new}))
    else $error("held value outside deadband of average");

  a_hist_store: assert property (@(posedge clk) disable iff (rst)
    hist_write |=> (sample_history[$past(s1_idx)][$past(s1_slot)] == $past(s1_sample)))
    else $error("sample not stored in history slot");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && s2_valid && out_valid && out_stall))
    else $error("input stalled with room in the pipeline");

endmodule : rc_channel_average_deadband
`default_nettype wire

// ----- test/rc_channel_average_deadband_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_channel_average_deadband_tb
// Drives channel samples through the averaging/deadband block under random
// sender gaps and receiver stalls, and checks every output item in order
// against a cycle-free predictor of the channel stores. A short scripted
// sequence covers the extremes, all receiver modes and the odd cases;
// framed random traffic follows under several register settings.
// ----------------------------------------------------------------------------
module rc_channel_average_deadband_tb;
  import rcad_pkg::*;

  localparam int NUM_CH        = 12;
  localparam int SETTLE_CYCLES = 6;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int DRAIN_TAIL    = 8;
  localparam int PHASE_ITEMS   = 175;
  localparam int PHASE_BLOCKS  = 5;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    channel_t chan;
    sample_t  value;
    logic     frame;
    logic     armed;
    logic     flag;
  } rc_sample_t;

  typedef struct packed {
    channel_t chan;
    sample_t  value;
    logic     acc;
  } rc_result_t;

  typedef enum logic {
    ROW_SAMPLE,
    ROW_WRITE
  } row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    reg_index_t reg_sel;
    sample_t    reg_data;
    rc_sample_t item;
    logic       has_answer;
    rc_result_t answer;
  } step_row_t;

  logic     clk;
  logic     rst           = 1'b1;
  logic     cfg_write     = 1'b0;
  logic     cfg_index     = REG_MODE;
  sample_t  cfg_data      = '0;
  logic     in_valid      = 1'b0;
  logic     in_stall;
  channel_t channel       = '0;
  sample_t  pulse_value   = '0;
  logic     frame_start   = 1'b0;
  logic     armed         = 1'b0;
  logic     link_failsafe = 1'b0;
  logic     out_valid;
  logic     out_stall     = 1'b0;
  channel_t out_channel;
  sample_t  filtered_value;
  logic     accepted;

  // typed answer travels with the item it belongs to
  logic       row_has_answer = 1'b0;
  rc_result_t row_answer     = '0;

  int send_pct = 0;
  int recv_pct = 0;
  int errors   = 0;

  // predictor copy of the block's state
  logic [1:0] mode_q = MODE_PULSE;
  sample_t    thr_q  = '0;
  slot_t      slot_q = '0;
  sample_t    hist_mem [NUM_CH][HIST_DEPTH];
  sample_t    held_mem [NUM_CH];

  rc_result_t pending_readings [$];
  step_row_t  script [$];

  // framed random traffic
  int      frame_cursor = 0;
  sample_t stick_level [NUM_CH];

  rc_channel_average_deadband #(
    .NUM_CHANNELS(NUM_CH)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .channel       (channel),
    .pulse_value   (pulse_value),
    .frame_start   (frame_start),
    .armed         (armed),
    .link_failsafe (link_failsafe),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_channel   (out_channel),
    .filtered_value(filtered_value),
    .accepted      (accepted)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("rc_channel_average_deadband_tb failed");
    $finish;
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  // Work out the reported reading for one sample and update the stores.
  function automatic rc_result_t condition_sample(rc_sample_t s);
    rc_result_t r;
    sum_t       total;
    sample_t    avg;
    sample_t    held;
    logic       ok;
    if (s.frame) begin
      slot_q = (slot_q == LAST_SLOT) ? slot_t'(0) : slot_q + slot_t'(1);
    end
    if (mode_q == MODE_SERIAL_FLAG) begin
      ok = s.flag || !s.armed;
    end else begin
      ok = (s.value > thr_q) || !s.armed;
    end
    r.chan  = s.chan;
    r.value = '0;
    r.acc   = 1'b0;
    if (s.chan < NUM_CH) begin
      held = held_mem[s.chan];
      if (ok) begin
        if (mode_q == MODE_SERIAL_FLAG || mode_q == MODE_SERIAL) begin
          held = s.value;
        end else begin
          total = sum_t'(s.value) + sum_t'(hist_mem[s.chan][0])
                + sum_t'(hist_mem[s.chan][1]) + sum_t'(hist_mem[s.chan][2]);
          avg = sample_t'((total + ROUNDING) >> 2);
          // lower test first; the upper one sees the updated held value
          if (avg + DEADBAND < held) held = sample_t'(avg + OFFSET);
          if (avg > held + DEADBAND) held = sample_t'(avg - OFFSET);
          hist_mem[s.chan][slot_q] = s.value;
        end
        held_mem[s.chan] = held;
      end
      r.value = held;
      r.acc   = ok;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_stall <= (recv_pct != 0) && ($urandom_range(0, 99) < recv_pct);
  end

  always @(posedge clk) begin : watch
    rc_result_t want;
    if (!rst) begin
      if (cfg_write) begin
        if (cfg_index == REG_MODE) mode_q = cfg_data[1:0];
        else thr_q = cfg_data;
      end
      if (in_valid && !in_stall) begin
        want = condition_sample('{channel, pulse_value, frame_start, armed,
                                   link_failsafe});
        if (row_has_answer) want = row_answer;
        pending_readings.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (pending_readings.size() == 0) begin
          report_mismatch("output item with nothing pending", out_channel, 0);
        end else begin
          want = pending_readings.pop_front();
          if (out_channel !== want.chan)
            report_mismatch("out_channel", out_channel, want.chan);
          if (filtered_value !== want.value)
            report_mismatch("filtered_value", filtered_value, want.value);
          if (accepted !== want.acc)
            report_mismatch("accepted", accepted, want.acc);
        end
      end
    end
  end

  task automatic put_sample(rc_sample_t s, logic has, rc_result_t ans);
    while ($urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    channel        <= s.chan;
    pulse_value    <= s.value;
    frame_start    <= s.frame;
    armed          <= s.armed;
    link_failsafe  <= s.flag;
    row_has_answer <= has;
    row_answer     <= ans;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Write only with the pipeline empty.
  task automatic write_reg(reg_index_t sel, sample_t data);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic step_row_t sample_row(channel_t c, sample_t v, logic f, logic a,
                                           logic l, logic has, sample_t av, logic aa);
    step_row_t row;
    row            = '0;
    row.kind       = ROW_SAMPLE;
    row.item       = '{c, v, f, a, l};
    row.has_answer = has;
    row.answer     = '{c, av, aa};
    return row;
  endfunction

  function automatic step_row_t write_row(reg_index_t sel, sample_t data);
    step_row_t row;
    row          = '0;
    row.kind     = ROW_WRITE;
    row.reg_sel  = sel;
    row.reg_data = data;
    return row;
  endfunction

  function automatic sample_t pick_level();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return sample_t'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic rc_sample_t next_random_sample();
    rc_sample_t s;
    int         v;
    if ($urandom_range(0, 99) < 80) begin
      // well-formed frame: channels in order, values jitter around a stick level
      s.chan  = channel_t'(frame_cursor);
      s.frame = (frame_cursor == 0);
      if ($urandom_range(0, 29) == 0) stick_level[frame_cursor] = pick_level();
      v = int'(stick_level[frame_cursor]) + int'($urandom_range(0, 12)) - 6;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      s.value = sample_t'(v);
      frame_cursor = (frame_cursor == NUM_CH - 1) ? 0 : frame_cursor + 1;
    end else begin
      s.chan  = channel_t'($urandom_range(0, 15));
      s.value = sample_t'($urandom);
      s.frame = 1'($urandom_range(0, 1));
    end
    s.armed = ($urandom_range(0, 9) != 0);
    s.flag  = ($urandom_range(0, 3) != 0);
    return s;
  endfunction

  task automatic random_config();
    logic [1:0] m;
    sample_t    t;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: m = MODE_PULSE;
      5, 6:          m = MODE_SERIAL_FLAG;
      7, 8:          m = MODE_SERIAL;
      default:       m = MODE_UNUSED;
    endcase
    case ($urandom_range(0, 3))
      0:       t = '0;
      1:       t = '1;
      2:       t = sample_t'($urandom);
      default: t = sample_t'($urandom_range(800, 2200));
    endcase
    // upper data bits are don't-care for the mode register
    write_reg(REG_MODE, {10'($urandom), m});
    write_reg(REG_THRESHOLD, t);
  endtask

  task automatic random_phase(int sp, int rp);
    send_pct = sp;
    recv_pct = rp;
    for (int b = 0; b < PHASE_BLOCKS; b++) begin
      random_config();
      for (int i = 0; i < PHASE_ITEMS / PHASE_BLOCKS; i++) begin
        put_sample(next_random_sample(), 1'b0, '0);
      end
    end
  endtask

  initial begin : main
    int waited;
    foreach (held_mem[c]) begin
      held_mem[c]    = '0;
      stick_level[c] = pick_level();
      for (int k = 0; k < HIST_DEPTH; k++) hist_mem[c][k] = '0;
    end

    // after reset: pulse mode, threshold 0
    script.push_back(sample_row(0, 0, 0, 1, 0, 1, 0, 0));
    script.push_back(sample_row(0, 0, 0, 0, 0, 1, 0, 1));
    script.push_back(sample_row(0, 4095, 0, 1, 1, 0, 0, 0));
    script.push_back(sample_row(0, 4095, 1, 1, 0, 0, 0, 0));
    script.push_back(sample_row(0, 4095, 1, 1, 0, 0, 0, 0));
    script.push_back(sample_row(0, 4095, 1, 1, 0, 0, 0, 0));
    // channels past the last one report zero and are never accepted
    script.push_back(sample_row(12, 100, 1, 1, 0, 1, 0, 0));
    script.push_back(sample_row(15, 4095, 1, 0, 1, 1, 0, 0));
    script.push_back(sample_row(11, 1, 0, 1, 0, 0, 0, 0));
    script.push_back(write_row(REG_THRESHOLD, '1));
    script.push_back(sample_row(3, 4095, 0, 1, 0, 1, 0, 0));
    script.push_back(sample_row(3, 4095, 0, 0, 0, 0, 0, 0));
    script.push_back(write_row(REG_MODE, sample_t'(MODE_SERIAL_FLAG)));
    script.push_back(sample_row(4, 4095, 0, 1, 0, 1, 0, 0));
    script.push_back(sample_row(4, 4095, 0, 1, 1, 1, 4095, 1));
    script.push_back(sample_row(4, 0, 0, 0, 0, 1, 0, 1));
    script.push_back(write_row(REG_MODE, sample_t'(MODE_SERIAL)));
    script.push_back(write_row(REG_THRESHOLD, '0));
    script.push_back(sample_row(7, 0, 0, 1, 0, 1, 0, 0));
    script.push_back(sample_row(7, 4095, 0, 1, 0, 1, 4095, 1));
    script.push_back(sample_row(7, 1, 0, 1, 1, 1, 1, 1));
    // unused mode code falls back to pulse filtering
    script.push_back(write_row(REG_MODE, {10'h3FF, MODE_UNUSED}));
    script.push_back(sample_row(7, 4095, 1, 1, 0, 0, 0, 0));
    script.push_back(sample_row(7, 0, 1, 0, 0, 0, 0, 0));
    script.push_back(write_row(REG_MODE, sample_t'(MODE_PULSE)));
    // small steps around a level exercise the deadband
    script.push_back(sample_row(2, 2048, 0, 1, 0, 0, 0, 0));
    script.push_back(sample_row(2, 2052, 0, 1, 0, 0, 0, 0));
    script.push_back(sample_row(2, 2046, 1, 1, 0, 0, 0, 0));
    script.push_back(sample_row(2, 2049, 1, 1, 0, 0, 0, 0));
    script.push_back(sample_row(11, 4095, 1, 1, 0, 0, 0, 0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_pct = 21;
    recv_pct = 81;
    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        write_reg(script[i].reg_sel, script[i].reg_data);
      end else begin
        put_sample(script[i].item, script[i].has_answer, script[i].answer);
      end
    end

    random_phase(21, 81);
    random_phase(81, 21);
    random_phase(0, 0);

    in_valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (pending_readings.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_TAIL) @(posedge clk);
    if (pending_readings.size() != 0)
      report_mismatch("output items never seen", pending_readings.size(), 0);

    if (errors == 0) begin
      $display("rc_channel_average_deadband_tb passed");
    end else begin
      $display("rc_channel_average_deadband_tb failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/rcad_pkg.sv
src/rc_channel_average_deadband.sv
test/rc_channel_average_deadband_tb.sv
